// ===== hdl/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and constants of the connection list decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

  localparam logic [5:0]  MAX_ENTRIES = 6'd32;

  localparam logic        ACT_BEGIN   = 1'b0;
  localparam logic        ACT_WORD    = 1'b1;

  localparam logic [1:0]  ST_OK       = 2'd0;
  localparam logic [1:0]  ST_BAD_ENTRY = 2'd1;
  localparam logic [1:0]  ST_FULL     = 2'd2;
  localparam logic [1:0]  ST_BAD_WORD = 2'd3;

  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [14:0] ID_LIMIT    = 15'd256;
  localparam logic [2:0]  PER_SHORT   = 3'd4;
  localparam logic [2:0]  PER_LONG    = 3'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] neighbor_id;
    logic       entry_valid;
    logic [5:0] entry_index;
    logic [1:0] status;
    logic       list_done;
    logic [5:0] total_entries;
    logic       last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic quick;
    logic can_push;
    logic out_free;
    logic step_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/cld_ctrl.sv =====
// ----------------------------------------------------------------------------
// cld_ctrl
// Sequencer: takes one item, steps the decoder once per cycle while the
// result stages have room, then hands the last result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cld_pkg::stat_t stat,
  output cld_pkg::cmd_t      cmd
);
  import cld_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.quick ? S_FLUSH : S_WORK;
        end
      end
      S_WORK: begin
        if (stat.can_push) begin
          cmd.step = 1'b1;
          if (stat.step_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cld_datapath.sv =====
// ----------------------------------------------------------------------------
// cld_datapath
// List state, slot and range decode, at most one result per step, a pending result
// stage and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cld_pkg::cmd_t   cmd,
  output cld_pkg::stat_t       stat,
  input  wire logic            action,
  input  wire logic [6:0]      entry_count,
  input  wire logic            long_entries,
  input  wire logic [31:0]     response,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cld_pkg::result_t     out_res
);
  import cld_pkg::*;

  // list state
  logic        list_open;
  logic        long_mode;
  logic [6:0]  expected_entries;
  logic [6:0]  raw_consumed;
  logic [7:0]  prev_id;
  logic        prev_valid;
  logic        prev_was_range;
  logic [5:0]  stored_count;

  // word walk
  logic [31:0] word;
  logic [2:0]  slot;
  logic        rng_active;
  logic [8:0]  rng_cur;
  logic [14:0] rng_end;

  // result stages
  result_t     pend;
  logic        pend_valid;

  logic        out_free;
  logic [2:0]  per;
  logic [7:0]  v8;
  logic [15:0] v16;
  logic [14:0] ent_id;
  logic        ent_rng;
  logic        slot_end;
  logic [7:0]  consumed_sum;
  logic [14:0] sid;
  logic        store_err;
  logic        rng_bad;
  logic        do_fail;
  logic [1:0]  fail_code;
  logic        store_ok;
  logic        rng_start;
  logic        word_end;
  logic        push;
  logic        rng_last;
  result_t     new_res;
  result_t     begin_res;
  result_t     badword_res;
  result_t     flush_res;

  assign out_free = !out_valid || out_ready;
  assign per      = long_mode ? PER_LONG : PER_SHORT;
  assign v8       = word[{slot[1:0], 3'b000} +: 8];
  assign v16      = word[{slot[0], 4'b0000} +: 16];
  assign ent_id   = long_mode ? v16[14:0] : {8'd0, v8[6:0]};
  assign ent_rng  = long_mode ? v16[15] : v8[7];
  assign slot_end = (slot >= per) ||
                    (({1'b0, raw_consumed} + {5'd0, slot}) >= {1'b0, expected_entries});
  assign consumed_sum = {1'b0, raw_consumed} + {5'd0, per};
  assign sid       = rng_active ? {6'd0, rng_cur} : ent_id;
  assign store_err = (sid >= ID_LIMIT) || (stored_count >= MAX_ENTRIES);
  assign rng_bad   = !prev_valid || prev_was_range || ({7'd0, prev_id} >= ent_id);
  assign rng_last  = ({6'd0, rng_cur} == rng_end);

  always_comb begin
    do_fail   = 1'b0;
    fail_code = ST_OK;
    store_ok  = 1'b0;
    rng_start = 1'b0;
    word_end  = 1'b0;
    priority if (rng_active) begin
      if (store_err) begin
        do_fail   = 1'b1;
        fail_code = ST_FULL;
      end else begin
        store_ok = 1'b1;
      end
    end else if (slot_end) begin
      word_end = 1'b1;
    end else if (ent_id == 15'd0) begin
      do_fail   = 1'b1;
      fail_code = ST_BAD_ENTRY;
    end else if (ent_rng) begin
      if (rng_bad) begin
        do_fail   = 1'b1;
        fail_code = ST_BAD_ENTRY;
      end else begin
        rng_start = 1'b1;
      end
    end else if (store_err) begin
      do_fail   = 1'b1;
      fail_code = ST_FULL;
    end else begin
      store_ok = 1'b1;
    end
  end

  assign push = do_fail || store_ok;

  always_comb begin
    new_res = '0;
    if (store_ok) begin
      new_res.neighbor_id   = sid[7:0];
      new_res.entry_valid   = 1'b1;
      new_res.entry_index   = stored_count;
      new_res.status        = ST_OK;
      new_res.total_entries = stored_count + 6'd1;
    end else begin
      new_res.entry_index   = stored_count;
      new_res.status        = fail_code;
      new_res.list_done     = 1'b1;
      new_res.total_entries = stored_count;
    end
  end

  always_comb begin
    begin_res           = '0;
    begin_res.list_done = (entry_count == 7'd0);
    badword_res               = '0;
    badword_res.entry_index   = stored_count;
    badword_res.status        = ST_BAD_WORD;
    badword_res.list_done     = 1'b1;
    badword_res.total_entries = stored_count;
    flush_res      = pend;
    flush_res.last = 1'b1;
  end

  assign stat.quick     = (action == ACT_BEGIN) || !list_open || (response == ALL_ONES);
  assign stat.can_push  = !pend_valid || out_free;
  assign stat.out_free  = out_free;
  assign stat.step_last = do_fail || word_end;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      list_open        <= 1'b0;
      long_mode        <= 1'b0;
      expected_entries <= 7'd0;
      raw_consumed     <= 7'd0;
      prev_id          <= 8'd0;
      prev_valid       <= 1'b0;
      prev_was_range   <= 1'b0;
      stored_count     <= 6'd0;
      slot             <= 3'd0;
      rng_active       <= 1'b0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.flush || (cmd.step && push && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        if (action == ACT_BEGIN) begin
          list_open        <= (entry_count != 7'd0);
          long_mode        <= long_entries;
          expected_entries <= entry_count;
          raw_consumed     <= 7'd0;
          prev_id          <= 8'd0;
          prev_valid       <= 1'b0;
          prev_was_range   <= 1'b0;
          stored_count     <= 6'd0;
          pend_valid       <= 1'b1;
        end else if (!list_open || (response == ALL_ONES)) begin
          list_open  <= 1'b0;
          pend_valid <= 1'b1;
        end else begin
          slot       <= 3'd0;
          rng_active <= 1'b0;
        end
      end
      if (cmd.step) begin
        if (push) begin
          pend_valid <= 1'b1;
        end
        if (do_fail) begin
          list_open  <= 1'b0;
          rng_active <= 1'b0;
        end
        if (store_ok) begin
          stored_count <= stored_count + 6'd1;
          if (rng_active) begin
            if (rng_last) begin
              rng_active     <= 1'b0;
              prev_id        <= rng_end[7:0];
              prev_valid     <= 1'b1;
              prev_was_range <= 1'b1;
              slot           <= slot + 3'd1;
            end
          end else begin
            prev_id        <= ent_id[7:0];
            prev_valid     <= 1'b1;
            prev_was_range <= 1'b0;
            slot           <= slot + 3'd1;
          end
        end
        if (rng_start) begin
          rng_active <= 1'b1;
        end
        if (word_end) begin
          if (consumed_sum >= {1'b0, expected_entries}) begin
            raw_consumed <= expected_entries;
            list_open    <= 1'b0;
          end else begin
            raw_consumed <= consumed_sum[6:0];
          end
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word <= response;
      if (action == ACT_BEGIN) begin
        pend <= begin_res;
      end else if (!list_open || (response == ALL_ONES)) begin
        pend <= badword_res;
      end
    end
    if (cmd.step) begin
      if (push) begin
        if (pend_valid) begin
          out_res <= pend;
        end
        pend <= new_res;
      end
      if (store_ok && rng_active) begin
        rng_cur <= rng_cur + 9'd1;
      end
      if (rng_start) begin
        rng_cur <= {1'b0, prev_id} + 9'd1;
        rng_end <= ent_id;
      end
      if (word_end && (consumed_sum >= {1'b0, expected_entries})) begin
        pend.list_done <= 1'b1;
      end
    end
    if (cmd.flush) begin
      out_res <= flush_res;
    end
  end

  a_flush_has_result: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> pend_valid)
    else $error("flush without a pending result");

  a_step_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!pend_valid || out_free))
    else $error("step while result stages are full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= MAX_ENTRIES)
    else $error("stored neighbor count above limit");

  a_range_sane: assert property (@(posedge clk) disable iff (rst)
    rng_active |-> (prev_valid && (rng_cur <= 9'd256)))
    else $error("range walk out of bounds");

endmodule

`default_nettype wire

// ===== hdl/connection_list_decoder_core.sv =====
// For a begin or a rejected word the controller moves to S_FLUSH, which loads the output
// register and raises out_valid; the next item can be taken once it is back in S_IDLE.
// A word takes the transfer, one step per neighbor, one more per range entry, one to close
// the word (none when it fails) and a flush to deliver the last result. The sequencer
// issues one step per cycle while the result stages have room; output stalls hold it.
// Reset (rst, synchronous, active high) closes any list and clears all list state.
// ----------------------------------------------------------------------------
// connection_list_decoder_core
// Decodes codec connection list words into one result per neighbor id, begin or error.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_list_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [6:0]  entry_count,
  input  wire logic        long_entries,
  input  wire logic [31:0] response,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       neighbor_id,
  output logic             entry_valid,
  output logic [5:0]       entry_index,
  output logic [1:0]       status,
  output logic             list_done,
  output logic [5:0]       total_entries,
  output logic             last
);
  import cld_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t out_res;

  cld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cld_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .entry_count  (entry_count),
    .long_entries (long_entries),
    .response     (response),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res)
  );

  assign neighbor_id   = out_res.neighbor_id;
  assign entry_valid   = out_res.entry_valid;
  assign entry_index   = out_res.entry_index;
  assign status        = out_res.status;
  assign list_done     = out_res.list_done;
  assign total_entries = out_res.total_entries;
  assign last          = out_res.last;

endmodule

`default_nettype wire
